/* sv/hqp_pkg.sv */
package hqp_pkg;

  // field widths of the request and result words
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned STATUS_W = 3;

  // default number of slots
  localparam int unsigned DEFAULT_TABLE_SIZE = 16;

  // home slot reduction: reciprocal multiply, then subtract and one correction
  localparam int unsigned HASH_STEPS = 2;
  localparam int unsigned HCNT_W     = $clog2(HASH_STEPS);

  // request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_FOUND    = 3'd2,
    ST_MISSING  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // one table entry as stored
  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic load_req;
    logic hash_step;
    logic probe_init;
    logic rd_en;
    logic check;
    logic load_out;
  } hqp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic hash_last;
    logic done;
  } hqp_stat_t;

endpackage

/* sv/hqp_datapath.sv */
module hqp_datapath import hqp_pkg::*; #(
  parameter int unsigned TABLE_SIZE = DEFAULT_TABLE_SIZE
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hqp_cmd_t          cmd,
  output hqp_stat_t         stat,
  input  logic              req_type,
  input  logic [KEY_W-1:0]  lookup_key,
  input  logic [VAL_W-1:0]  payload,
  output status_t           status,
  output logic [VAL_W-1:0]  found_value,
  output logic [SLOT_W-1:0] slot
);

  localparam int unsigned AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam logic [AW:0]   N_EXT   = (AW+1)'(TABLE_SIZE);
  localparam logic [AW-1:0] LAST_IX = AW'(TABLE_SIZE - 1);
  localparam logic [AW-1:0] INC0    = AW'(1 % TABLE_SIZE);
  localparam logic [AW-1:0] ODD0    = AW'(3 % TABLE_SIZE);
  localparam logic [AW:0]   TWO     = (AW+1)'(2);

  // reciprocal of the table size; its quotient estimate is at most one low
  localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / TABLE_SIZE);

  // request registers
  logic                 req_type_r;
  logic [KEY_W-1:0]     key_r;
  logic [VAL_W-1:0]     payload_r;

  // home slot reduction
  logic [2*KEY_W-1:0]   prod_r;
  logic [AW-1:0]        rem_nxt;
  logic [HCNT_W-1:0]    hcnt_r;

  // probe walk: slot, next square increment and next odd step, all mod table size
  logic [AW-1:0]        pos_r;
  logic [AW-1:0]        inc_r;
  logic [AW-1:0]        odd_r;
  logic [AW-1:0]        step_r;
  logic [AW-1:0]        pos_nxt;
  logic [AW-1:0]        inc_nxt;
  logic [AW-1:0]        odd_nxt;

  // table memory and clearing pass
  entry_t               mem [TABLE_SIZE];
  entry_t               rd_q_r;
  entry_t               wdata;
  logic [AW-1:0]        clr_r;

  // probe decision
  logic                 hit_used;
  logic                 hit_match;
  logic                 chk_done;
  logic                 chk_wr;
  status_t              chk_status;
  logic [VAL_W-1:0]     chk_value;
  logic [SLOT_W-1:0]    chk_slot;

  // result held until the output register is free
  status_t              res_status_r;
  logic [VAL_W-1:0]     res_value_r;
  logic [SLOT_W-1:0]    res_slot_r;
  status_t              out_status_r;
  logic [VAL_W-1:0]     out_value_r;
  logic [SLOT_W-1:0]    out_slot_r;

  // key minus quotient estimate times table size, in the low bits only, then one correction
  always_comb begin
    logic [AW:0] qn_lo;
    logic [AW:0] t;
    qn_lo = prod_r[KEY_W+AW:KEY_W] * N_EXT;
    t     = key_r[AW:0] - qn_lo;
    if (t >= N_EXT) t = t - N_EXT;
    rem_nxt = t[AW-1:0];
  end

  // next probe slot and increments, one compare and subtract each
  always_comb begin
    logic [AW:0] sp;
    logic [AW:0] si;
    logic [AW:0] so;
    sp = {1'b0, pos_r} + {1'b0, inc_r};
    si = {1'b0, inc_r} + {1'b0, odd_r};
    so = {1'b0, odd_r} + TWO;
    if (sp >= N_EXT) sp = sp - N_EXT;
    if (si >= N_EXT) si = si - N_EXT;
    if (so >= N_EXT) so = so - N_EXT;
    pos_nxt = sp[AW-1:0];
    inc_nxt = si[AW-1:0];
    odd_nxt = so[AW-1:0];
  end

  // decide on the entry just read
  always_comb begin
    hit_used   = rd_q_r.used;
    hit_match  = rd_q_r.used && (rd_q_r.key == key_r);
    chk_done   = !hit_used || hit_match || (step_r == LAST_IX);
    chk_wr     = 1'b0;
    chk_status = ST_MISSING;
    chk_value  = '0;
    chk_slot   = '0;
    wdata      = '{used: 1'b1, key: key_r, value: payload_r};
    priority if (!hit_used) begin
      if (req_type_r == REQ_INSERT) begin
        chk_status = ST_INSERTED;
        chk_slot   = SLOT_W'(pos_r);
        chk_wr     = 1'b1;
      end
    end else if (hit_match) begin
      chk_slot = SLOT_W'(pos_r);
      if (req_type_r == REQ_SEARCH) begin
        chk_status = ST_FOUND;
        chk_value  = rd_q_r.value;
      end else begin
        chk_status = ST_UPDATED;
        chk_wr     = 1'b1;
      end
    end else begin
      if (req_type_r == REQ_INSERT) chk_status = ST_FULL;
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      hcnt_r <= '0;
    end else begin
      if (cmd.clr_wr) clr_r <= clr_r + AW'(1);
      if (cmd.load_req) hcnt_r <= '0;
      else if (cmd.hash_step) hcnt_r <= hcnt_r + HCNT_W'(1);
    end
  end

  // request, reduction and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_type_r <= req_type;
      key_r      <= lookup_key;
      payload_r  <= payload;
    end else if (cmd.hash_step) begin
      prod_r <= (2*KEY_W)'(key_r) * (2*KEY_W)'(RECIP);
    end
    if (cmd.probe_init) begin
      pos_r  <= rem_nxt;
      inc_r  <= INC0;
      odd_r  <= ODD0;
      step_r <= '0;
    end else if (cmd.check && !chk_done) begin
      pos_r  <= pos_nxt;
      inc_r  <= inc_nxt;
      odd_r  <= odd_nxt;
      step_r <= step_r + AW'(1);
    end
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) mem[clr_r] <= '0;
    else if (cmd.check && chk_wr) mem[pos_r] <= wdata;
    if (cmd.rd_en) rd_q_r <= mem[pos_r];
  end

  // result and output registers
  always_ff @(posedge clk) begin
    if (cmd.check && chk_done) begin
      res_status_r <= chk_status;
      res_value_r  <= chk_value;
      res_slot_r   <= chk_slot;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_slot_r   <= res_slot_r;
    end
  end

  assign stat.clr_last  = (clr_r == LAST_IX);
  assign stat.hash_last = (hcnt_r == HCNT_W'(HASH_STEPS - 1));
  assign stat.done      = chk_done;

  assign status      = out_status_r;
  assign found_value = out_value_r;
  assign slot        = out_slot_r;

endmodule

/* sv/hqp_ctrl.sv */
module hqp_ctrl import hqp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  hqp_stat_t stat,
  output hqp_cmd_t  cmd,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // command decode and next state
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (stat.hash_last) begin
          cmd.probe_init = 1'b1;
          state_nxt      = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = stat.done ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* sv/hash_table_quadratic_probe_core.sv */
// Open-addressed key/value table with quadratic probing over TABLE_SIZE slots. A request word
// carries the kind in in_tuser (insert/update or search) and key plus value in in_tdata; each
// request gives exactly one result word, with the status code in out_tuser and the found value
// and slot in out_tdata. After reset a clearing pass empties the table slot by slot while
// in_tready stays low. A request is accepted in the idle state, its key is reduced to its
// home slot (a reciprocal multiply, then a subtract with one correction), from 1 to
// TABLE_SIZE slots are probed, each with a registered read of the single table memory and
// then a compare, and the result is handed to the output register once that register is free.
// One request is worked on at a time; a finished result may wait in the output register while
// the next request is taken and processed.
module hash_table_quadratic_probe_core import hqp_pkg::*; #(
  parameter int unsigned TABLE_SIZE = DEFAULT_TABLE_SIZE
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [63:0]         in_tdata,   // lookup_key[30:0], payload[62:31], zero pad
  input  logic                in_tuser,   // req_type
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [39:0]         out_tdata,  // found_value[31:0], slot[35:32], zero pad
  output logic [STATUS_W-1:0] out_tuser   // status
);

  hqp_cmd_t          cmd;
  hqp_stat_t         stat;
  status_t           status;
  logic [VAL_W-1:0]  found_value;
  logic [SLOT_W-1:0] slot;

  hqp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat       (stat),
    .cmd        (cmd),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  hqp_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .req_type    (in_tuser),
    .lookup_key  (in_tdata[KEY_W-1:0]),
    .payload     (in_tdata[KEY_W+VAL_W-1:KEY_W]),
    .status      (status),
    .found_value (found_value),
    .slot        (slot)
  );

  // result word packing
  assign out_tdata = {4'b0000, slot, found_value};
  assign out_tuser = status;

endmodule

/* test/hqp_result_checker.sv */
`timescale 1ns / 1ps

module hqp_result_checker import hqp_pkg::*; #(
  parameter int unsigned TABLE_SIZE = DEFAULT_TABLE_SIZE
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [63:0]         in_tdata,   // lookup_key[30:0], payload[62:31], zero pad
  input  logic                in_tuser,   // req_type
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [39:0]         out_tdata,  // found_value[31:0], slot[35:32], zero pad
  input  logic [STATUS_W-1:0] out_tuser,  // status
  output int                  fail_count,
  output int                  pending,
  output int                  checked
);

  typedef struct packed {
    status_t           status;
    logic [VAL_W-1:0]  value;
    logic [SLOT_W-1:0] slot;
  } result_t;

  // shadow copy of the table
  logic              used_mark [TABLE_SIZE];
  logic [KEY_W-1:0]  key_mem   [TABLE_SIZE];
  logic [VAL_W-1:0]  val_mem   [TABLE_SIZE];

  result_t expected_results [$];

  // walk the quadratic probe sequence, update the shadow table, return the answer word
  function automatic result_t probe_table(input logic kind, input logic [KEY_W-1:0] k,
                                          input logic [VAL_W-1:0] v);
    result_t     r;
    int unsigned pos;
    pos      = k % TABLE_SIZE;
    r.status = (kind == REQ_SEARCH) ? ST_MISSING : ST_FULL;
    r.value  = '0;
    r.slot   = '0;
    for (int unsigned s = 0; s < TABLE_SIZE; s++) begin
      if (s != 0) pos = (pos + (s * s) % TABLE_SIZE) % TABLE_SIZE;
      // free slot ends the walk: claim it or report a miss
      if (!used_mark[pos]) begin
        if (kind == REQ_INSERT) begin
          key_mem[pos]   = k;
          val_mem[pos]   = v;
          used_mark[pos] = 1'b1;
          r.status       = ST_INSERTED;
          r.slot         = pos[SLOT_W-1:0];
        end
        return r;
      end
      // matching key ends the walk: update or hand back the value
      if (key_mem[pos] == k) begin
        if (kind == REQ_INSERT) begin
          val_mem[pos] = v;
          r.status     = ST_UPDATED;
        end else begin
          r.status = ST_FOUND;
          r.value  = val_mem[pos];
        end
        r.slot = pos[SLOT_W-1:0];
        return r;
      end
    end
    return r;
  endfunction

  // watch both channels at every edge
  always @(posedge clk) begin
    result_t got;
    result_t want;
    int      errs;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_SIZE; i++) used_mark[i] = 1'b0;
      expected_results.delete();
      pending <= 0;
    end else begin
      // result word against the oldest expectation
      if (out_tvalid && out_tready) begin
        got.status = status_t'(out_tuser);
        got.value  = out_tdata[VAL_W-1:0];
        got.slot   = out_tdata[VAL_W+SLOT_W-1:VAL_W];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word, status %0d value %h slot %0d",
                   $time, got.status, got.value, got.slot);
          errs = 1;
        end else begin
          want = expected_results.pop_front();
          if (got.status != want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            errs++;
          end
          if (got.value != want.value) begin
            $display("%0t: found_value expected %h, got %h", $time, want.value, got.value);
            errs++;
          end
          if (got.slot != want.slot) begin
            $display("%0t: slot expected %0d, got %0d", $time, want.slot, got.slot);
            errs++;
          end
          checked <= checked + 1;
        end
      end
      // request word: predict its answer
      if (in_tvalid && in_tready)
        expected_results.push_back(probe_table(in_tuser, in_tdata[KEY_W-1:0],
                                               in_tdata[KEY_W+VAL_W-1:KEY_W]));
      pending <= expected_results.size();
    end
    fail_count <= fail_count + errs;
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top import hqp_pkg::*; ();

  localparam int unsigned N_SLOTS      = DEFAULT_TABLE_SIZE;
  localparam int          RANDOM_REQS  = 1800;
  localparam int          KEY_POOL     = 24;
  localparam int          HOLD_AT      = 600;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          PAUSE_AT     = 900;
  localparam int          DRAIN_CYCLES = 60;
  localparam int          CYCLE_LIMIT  = 600000;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [63:0]         in_tdata;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [39:0]         out_tdata;
  logic [STATUS_W-1:0] out_tuser;

  int fail_count;
  int pending;
  int checked;
  int sent;
  int searches;
  int cycle_cnt;
  bit calm;

  logic [KEY_W-1:0] key_pool [KEY_POOL];

  hash_table_quadratic_probe_core #(.TABLE_SIZE(N_SLOTS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  hqp_result_checker #(.TABLE_SIZE(N_SLOTS)) result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one request word after a random gap, return once it is taken
  task automatic send_request(input logic kind, input logic [KEY_W-1:0] k,
                              input logic [VAL_W-1:0] v);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, v, k};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    sent++;
    if (kind == REQ_SEARCH) searches++;
  endtask

  // result side: random stalls, one long hold-off
  initial begin
    int stall;
    int taken;
    taken = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 6);
      if (taken == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  // request side and verdict
  initial begin
    logic             kind;
    logic [KEY_W-1:0] k;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= REQ_INSERT;
    rst_n     <= 1'b0;
    calm = 1'b0;
    sent = 0;
    searches = 0;

    // pool of keys, many sharing a few home slots
    for (int i = 0; i < KEY_POOL; i++) begin
      key_pool[i] = KEY_W'($urandom);
      if (i < 18) key_pool[i][SLOT_W-1:0] = SLOT_W'(i % 6 + 2);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty-table miss, key and value extremes, update, found
    send_request(REQ_SEARCH, KEY_W'(5), 32'hFFFF_FFFF);
    send_request(REQ_INSERT, '0, '0);
    send_request(REQ_INSERT, {KEY_W{1'b1}}, 32'hFFFF_FFFF);
    send_request(REQ_SEARCH, {KEY_W{1'b1}}, '0);
    send_request(REQ_INSERT, '0, 32'hFFFF_FFFF);
    send_request(REQ_SEARCH, '0, 32'hFFFF_FFFF);
    // collide on home slot zero until its whole walk is taken
    for (int j = 1; j <= 10; j++) send_request(REQ_INSERT, KEY_W'(16 * j), $urandom);
    // walk exhausted: table full on insert, miss on search
    send_request(REQ_INSERT, KEY_W'(16 * 11), $urandom);
    send_request(REQ_SEARCH, KEY_W'(16 * 11), $urandom);
    send_request(REQ_SEARCH, KEY_W'(16 * 10), $urandom);
    send_request(REQ_INSERT, KEY_W'(16 * 5), 32'h5A5A_5A5A);
    send_request(REQ_SEARCH, KEY_W'(32'h4000_0000), $urandom);
    send_request(REQ_INSERT, KEY_W'(2), $urandom);

    // random: mostly pooled keys so updates and hits keep coming, the rest wide keys
    for (int n = 0; n < RANDOM_REQS; n++) begin
      calm = (n >= 300 && n < 450) || (n >= 1100 && n < 1200);
      if (n == PAUSE_AT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      kind = $urandom_range(0, 1) ? REQ_SEARCH : REQ_INSERT;
      if ($urandom_range(0, 99) < 80) k = key_pool[$urandom_range(0, KEY_POOL - 1)];
      else k = KEY_W'($urandom);
      send_request(kind, k, $urandom);
    end

    // drain
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests (%0d searches) driven, %0d answers compared", sent, searches,
             checked);
    $display("run took one probe walk to table full, exhausted searches, a %0d-cycle %s",
             HOLD_CYCLES, "output hold-off and a full drain pause");
    if (fail_count == 0 && pending == 0) begin
      $display("hash_table_quadratic_probe_core: match");
    end else begin
      $display("hash_table_quadratic_probe_core: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d answers outstanding", cycle_cnt, pending);
    $display("hash_table_quadratic_probe_core: mismatch");
    $finish;
  end

endmodule

/* sim.f */
sv/hqp_pkg.sv
sv/hqp_datapath.sv
sv/hqp_ctrl.sv
sv/hash_table_quadratic_probe_core.sv
test/hqp_result_checker.sv
test/tb_top.sv
